[rtl/core/hsc_pkg.sv]
`timescale 1ns / 1ps

package hsc_pkg;

    // FNV-1a constants
    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    // failure count at which a query answer is raised by one
    localparam logic [7:0] ESCALATE_FAILS = 8'd3;

    // operation codes
    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    // reset value of the strategy cap
    localparam logic [7:0] MAX_STRATEGY_RST = 8'd3;

    // one slot of the table
    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  strategy;
        logic [7:0]  failures;
        logic [31:0] success_time;
        logic [31:0] hits;
    } t_entry;

endpackage

[rtl/core/hsc_req_if.sv]
`timescale 1ns / 1ps

interface hsc_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] address;
    logic [7:0]  strategy;
    logic        success;
    logic [31:0] now;

    modport source (output valid, func, address, strategy, success, now, input ready);
    modport sink (input valid, func, address, strategy, success, now, output ready);
endinterface

[rtl/core/hsc_rsp_if.sv]
`timescale 1ns / 1ps

interface hsc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  strategy_out;
    logic        known;
    logic        evicted;
    logic [8:0]  entry_count;
    logic [31:0] total_hits;

    modport source (output valid, strategy_out, known, evicted, entry_count, total_hits,
                    input ready);
    modport sink (input valid, strategy_out, known, evicted, entry_count, total_hits,
                  output ready);
endinterface

[rtl/core/hsc_cfg_if.sv]
`timescale 1ns / 1ps

interface hsc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/core/hashed_strategy_cache.sv]
`timescale 1ns / 1ps
// Steps from acceptance to result valid: address 0 goes straight to the result load. Others
//   run the hash (plus a modulo step when SLOT_COUNT is not a power of two), a read and a
//   compare per probe, a write on reports and the result load; a full-table report also scans every slot for a victim.
// One item at a time; the next is accepted in the cycle after the result loads.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every slot of the store
//   while no transaction is accepted. max_strategy resets to 3.
module hashed_strategy_cache #(
    parameter int SLOT_COUNT = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hsc_req_if.sink          i_req,
    hsc_cfg_if.sink          i_cfg,
    hsc_rsp_if.source        o_rsp
);
    import hsc_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PCMP  = 4'd4;
    localparam logic [3:0] S_SRD   = 4'd5;
    localparam logic [3:0] S_SCMP  = 4'd6;
    localparam logic [3:0] S_EVICT = 4'd7;
    localparam logic [3:0] S_WR    = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_best_idx, n_best_idx;
    t_entry        r_best, n_best;
    t_entry        r_wentry, n_wentry;
    logic          r_func, r_succ;
    logic [31:0]   r_addr, r_now;
    logic [7:0]    r_strat, r_max;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_hits_sum, n_hits_sum;
    logic [7:0]    r_ans, n_ans;
    logic          r_known, n_known, r_evicted, n_evicted;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_o_strategy;
    logic          r_o_known, r_o_evicted;
    logic [8:0]    r_o_count;
    logic [31:0]   r_o_hits;

    logic          w_accept, w_load;
    logic          w_hash_start, w_hash_done;
    logic [IW-1:0] w_hash_slot;
    logic          w_we;
    t_entry        w_wdata, w_rdata;

    // record an outcome into a slot
    function automatic t_entry apply_outcome(t_entry e, logic succ, logic [7:0] strat,
                                             logic [31:0] now);
        t_entry r;
        r = e;
        if (succ) begin
            r.strategy     = strat;
            r.failures     = 8'd0;
            r.success_time = now;
            if (e.hits != '1) begin
                r.hits = e.hits + 32'd1;
            end
        end else if (e.failures != 8'hFF) begin
            r.failures = e.failures + 8'd1;
        end
        return r;
    endfunction

    hsc_hash #(.SLOT_COUNT(SLOT_COUNT)) u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_hash_start),
        .i_address (r_addr),
        .o_done    (w_hash_done),
        .o_slot    (w_hash_slot)
    );

    hsc_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (r_idx),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign i_req.ready  = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_load       = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign w_hash_start = (r_state == S_HASH) && !w_hash_done && (r_cnt == '0)
                          && (r_best_idx == '1);
    assign w_we         = (r_state == S_CLR) || (r_state == S_WR);
    assign w_wdata      = (r_state == S_CLR) ? '0 : r_wentry;

    // sequencer
    always_comb begin
        t_entry base;
        logic   inc;
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_wentry    = r_wentry;
        n_count     = r_count;
        n_hits_sum  = r_hits_sum;
        n_ans       = r_ans;
        n_known     = r_known;
        n_evicted   = r_evicted;
        n_out_valid = r_out_valid;
        base        = '0;
        base.address = r_addr;
        inc         = 1'b0;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLR: begin
                n_idx = r_idx + IW'(1);
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_ans      = 8'd0;
                    n_known    = 1'b0;
                    n_evicted  = 1'b0;
                    n_cnt      = '0;
                    n_best_idx = '1;
                    n_state    = (i_req.address == 32'd0) ? S_DONE : S_HASH;
                end
            end
            S_HASH: begin
                // start pulse is marked by r_best_idx all ones, cleared after launch
                n_best_idx = '0;
                if (w_hash_done) begin
                    n_idx   = w_hash_slot;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PCMP;
            end
            S_PCMP: begin
                if (w_rdata.address == r_addr) begin
                    n_known = 1'b1;
                    if (r_func == FUNC_QUERY) begin
                        n_ans = w_rdata.strategy;
                        if (w_rdata.failures >= ESCALATE_FAILS && w_rdata.strategy < r_max) begin
                            n_ans = w_rdata.strategy + 8'd1;
                        end
                        n_state = S_DONE;
                    end else begin
                        inc        = r_succ && (w_rdata.hits != '1);
                        n_wentry   = apply_outcome(w_rdata, r_succ, r_strat, r_now);
                        n_hits_sum = r_hits_sum + {31'd0, inc};
                        n_state    = S_WR;
                    end
                end else if (w_rdata.address == 32'd0) begin
                    if (r_func == FUNC_QUERY) begin
                        n_state = S_DONE;
                    end else begin
                        n_count    = r_count + CW'(1);
                        n_wentry   = apply_outcome(base, r_succ, r_strat, r_now);
                        n_hits_sum = r_hits_sum + {31'd0, r_succ};
                        n_state    = S_WR;
                    end
                end else if (r_cnt == LAST) begin
                    // every slot holds another address
                    if (r_func == FUNC_QUERY) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SRD;
                    end
                end else begin
                    n_cnt   = r_cnt + IW'(1);
                    n_idx   = (r_idx == LAST) ? '0 : r_idx + IW'(1);
                    n_state = S_PRD;
                end
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                // oldest success wins, lowest index on ties
                if (r_idx == '0 || w_rdata.success_time < r_best.success_time) begin
                    n_best     = w_rdata;
                    n_best_idx = r_idx;
                end
                if (r_idx == LAST) begin
                    n_state = S_EVICT;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SRD;
                end
            end
            S_EVICT: begin
                n_evicted  = 1'b1;
                n_idx      = r_best_idx;
                n_wentry   = apply_outcome(base, r_succ, r_strat, r_now);
                n_hits_sum = r_hits_sum - r_best.hits + {31'd0, r_succ};
                n_state    = S_WR;
            end
            S_WR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_count     <= '0;
            r_hits_sum  <= '0;
            r_max       <= MAX_STRATEGY_RST;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_best_idx  <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_hits_sum  <= n_hits_sum;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_best_idx  <= n_best_idx;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max <= i_cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_best    <= n_best;
        r_wentry  <= n_wentry;
        r_ans     <= n_ans;
        r_known   <= n_known;
        r_evicted <= n_evicted;
        if (w_accept) begin
            r_func  <= i_req.func;
            r_addr  <= i_req.address;
            r_strat <= i_req.strategy;
            r_succ  <= i_req.success;
            r_now   <= i_req.now;
        end
        if (w_load) begin
            r_o_strategy <= r_ans;
            r_o_known    <= r_known;
            r_o_evicted  <= r_evicted;
            r_o_count    <= 9'(r_count);
            r_o_hits     <= r_hits_sum;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.strategy_out = r_o_strategy;
    assign o_rsp.known        = r_o_known;
    assign o_rsp.evicted      = r_o_evicted;
    assign o_rsp.entry_count  = r_o_count;
    assign o_rsp.total_hits   = r_o_hits;

    // checks
    a_evict_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_evicted |-> !r_o_known)
        else $error("eviction reported for a known address");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOT_COUNT))
        else $error("entry count above slot count");

    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.address == 32'd0 |=> r_state == S_DONE)
        else $error("reserved address not bypassed");

    a_hash_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_done |-> r_state == S_HASH)
        else $error("hash result outside hash wait");

endmodule

[rtl/core/hsc_hash.sv]
`timescale 1ns / 1ps

// Iterative FNV-1a over four address bytes (one multiply per cycle),
// then home slot by mask or by reciprocal multiply with one correction.
module hsc_hash #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [31:0]                   i_address,
    output logic                          o_done,
    output logic [$clog2(SLOT_COUNT)-1:0] o_slot
);
    import hsc_pkg::*;

    localparam int IW      = $clog2(SLOT_COUNT);
    localparam bit IS_POW2 = (SLOT_COUNT == (1 << IW));
    localparam logic [31:0] SLOT_W = 32'(SLOT_COUNT);
    // floor(2^32 / SLOT_COUNT)
    localparam logic [31:0] RECIP  = 32'(64'h1_0000_0000 / 64'(SLOT_COUNT));

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_MUL  = 2'd1;
    localparam logic [1:0] H_MOD  = 2'd2;
    localparam logic [1:0] H_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [31:0]   r_h, n_h;
    logic [31:0]   r_bytes, n_bytes;
    logic [4:0]    r_step, n_step;
    logic [IW-1:0] r_rem, n_rem;
    logic [31:0]   r_q, n_q;
    logic [63:0]   w_prod;
    logic [31:0]   w_diff;

    // sequencer and multiply / subtract datapath
    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_bytes = r_bytes;
        n_step  = r_step;
        n_rem   = r_rem;
        n_q     = r_q;
        w_prod  = 64'(r_h) * 64'(RECIP);
        w_diff  = r_h - r_q;
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_h     = FNV_BASIS;
                    n_bytes = i_address;
                    n_step  = 5'd0;
                    n_state = H_MUL;
                end
            end
            H_MUL: begin
                n_h     = (r_h ^ {24'd0, r_bytes[7:0]}) * FNV_PRIME;
                n_bytes = r_bytes >> 8;
                n_step  = r_step + 5'd1;
                if (r_step == 5'd3) begin
                    n_step  = 5'd0;
                    n_rem   = '0;
                    n_state = IS_POW2 ? H_DONE : H_MOD;
                end
            end
            H_MOD: begin
                // quotient estimate, back-multiply, then at most one subtract
                if (r_step == 5'd0) begin
                    n_q    = w_prod[63:32];
                    n_step = 5'd1;
                end else if (r_step == 5'd1) begin
                    n_q    = r_q * SLOT_W;
                    n_step = 5'd2;
                end else begin
                    if (w_diff >= SLOT_W) begin
                        w_diff = w_diff - SLOT_W;
                    end
                    n_rem   = w_diff[IW-1:0];
                    n_step  = 5'd0;
                    n_state = H_DONE;
                end
            end
            H_DONE: begin
                n_state = H_IDLE;
            end
            default: begin
                n_state = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_h     <= n_h;
        r_bytes <= n_bytes;
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_q     <= n_q;
    end

    assign o_done = (r_state == H_DONE);
    assign o_slot = IS_POW2 ? r_h[IW-1:0] : r_rem;

endmodule

[rtl/core/hsc_mem.sv]
`timescale 1ns / 1ps

// Slot store: one write port, one registered read port.
module hsc_mem #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_addr,
    input  hsc_pkg::t_entry               i_wdata,
    output hsc_pkg::t_entry               o_rdata
);
    import hsc_pkg::*;

    t_entry r_mem [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
